// ----- rtl/pidsci_pkg.sv -----
// shared types, reset values and helpers of the pid step block
package pidsci_pkg;

  // default fixed point and drive floor
  localparam int unsigned FracBitsDefault    = 20;
  localparam int unsigned OutputFloorDefault = 8000;

  // register reset values
  localparam logic [15:0] SetpointRst = 16'd0;
  localparam logic [31:0] GainPRst    = 32'd193986560;
  localparam logic [31:0] GainIRst    = 32'd3146;
  localparam logic [31:0] GainDRst    = 32'd419;
  localparam logic [16:0] SepLimitRst = 17'd131071;
  localparam logic [31:0] SumUpperRst = 32'h7FFF_FFFF;
  localparam logic [31:0] SumLowerRst = 32'h8000_0000;
  localparam logic [15:0] OutMaxRst   = 16'hFFFF;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    RegSetpoint  = 3'd0,
    RegGainP     = 3'd1,
    RegGainI     = 3'd2,
    RegGainD     = 3'd3,
    RegSepLimit  = 3'd4,
    RegSumUpper  = 3'd5,
    RegSumLower  = 3'd6,
    RegOutputMax = 3'd7
  } cfg_reg_e;

  // error stage: current error, integral enable, updated sum, derivative
  typedef struct packed {
    logic [16:0] err;
    logic        used;
    logic [31:0] sum;
    logic [17:0] de;
  } err_stage_t;

  // product stage: the three gain products plus the passed-along fields
  typedef struct packed {
    logic [49:0] prod_p;
    logic [63:0] prod_i;
    logic [50:0] prod_d;
    logic [16:0] err;
    logic        used;
  } prod_stage_t;

  // signed 64-bit add that saturates at the 64-bit limits
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

endpackage

// ----- rtl/pidsci_err.sv -----
// error forming, integral separation, conditional accumulation and error history
module pidsci_err (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    accept_i,
  input  logic [15:0]             meas_i,
  input  logic [15:0]             setpoint_i,
  input  logic [16:0]             sep_limit_i,
  input  logic [31:0]             sum_upper_i,
  input  logic [31:0]             sum_lower_i,
  output pidsci_pkg::err_stage_t  stage_o
);

  logic signed [31:0] sum_q, sum_d;
  logic signed [16:0] last_q, last_d;
  logic signed [16:0] prev_q, prev_d;
  pidsci_pkg::err_stage_t stage_q, stage_d;

  logic signed [16:0] err;
  logic [16:0]        mag;
  logic               used;
  logic signed [16:0] last_eff;
  logic               above, below, add_en;
  logic signed [32:0] sum_ext;
  logic signed [31:0] sum_sat;
  logic signed [17:0] de;

  // error and its magnitude
  assign err  = {setpoint_i[15], setpoint_i} - {meas_i[15], meas_i};
  assign mag  = err[16] ? 17'(-err) : err;
  assign used = (mag <= sep_limit_i);

  // an empty history takes the current error
  assign last_eff = (last_q == '0) ? err : last_q;

  // accumulate only errors that pull the sum back once at a limit
  assign above = (sum_q >= $signed(sum_upper_i));
  assign below = (sum_q <= $signed(sum_lower_i));
  always_comb begin
    if (above) begin
      add_en = used & err[16];
    end else if (below) begin
      add_en = used & ~err[16] & (err != '0);
    end else begin
      add_en = used;
    end
  end

  // saturating 32-bit accumulate
  assign sum_ext = {sum_q[31], sum_q} + {{16{err[16]}}, err};
  always_comb begin
    if (sum_ext[32] != sum_ext[31]) begin
      sum_sat = sum_ext[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end else begin
      sum_sat = sum_ext[31:0];
    end
  end

  assign de = {last_eff[16], last_eff} - {prev_q[16], prev_q};

  // state and stage next values
  always_comb begin
    sum_d  = sum_q;
    last_d = last_q;
    prev_d = prev_q;
    if (accept_i) begin
      sum_d  = add_en ? sum_sat : sum_q;
      prev_d = last_eff;
      last_d = err;
    end
    stage_d.err  = err;
    stage_d.used = used;
    stage_d.sum  = add_en ? sum_sat : sum_q;
    stage_d.de   = de;
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      last_q <= '0;
      prev_q <= '0;
    end else begin
      sum_q  <= sum_d;
      last_q <= last_d;
      prev_q <= prev_d;
    end
  end

  // stage register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ----- rtl/pidsci_mult.sv -----
// the three gain products, registered
module pidsci_mult (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [31:0]              gain_p_i,
  input  logic [31:0]              gain_i_i,
  input  logic [31:0]              gain_d_i,
  input  pidsci_pkg::err_stage_t   stage_i,
  output pidsci_pkg::prod_stage_t  stage_o
);

  logic signed [16:0] err_s;
  logic signed [31:0] sum_s;
  logic signed [17:0] de_s;
  logic signed [32:0] gp_s, gi_s, gd_s;
  logic signed [49:0] prod_p;
  logic signed [64:0] prod_i;
  logic signed [50:0] prod_d;
  pidsci_pkg::prod_stage_t stage_d, stage_q;

  assign err_s = stage_i.err;
  assign sum_s = stage_i.sum;
  assign de_s  = stage_i.de;
  assign gp_s  = {1'b0, gain_p_i};
  assign gi_s  = {1'b0, gain_i_i};
  assign gd_s  = {1'b0, gain_d_i};

  // unsigned gains times signed terms
  assign prod_p = gp_s * err_s;
  assign prod_i = gi_s * sum_s;
  assign prod_d = gd_s * de_s;

  // integral product dropped when the error is beyond the separation limit
  always_comb begin
    stage_d.prod_p = prod_p;
    stage_d.prod_i = stage_i.used ? prod_i[63:0] : '0;
    stage_d.prod_d = prod_d;
    stage_d.err    = stage_i.err;
    stage_d.used   = stage_i.used;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ----- rtl/pidsci_out.sv -----
// saturating sum of the products, scaling and drive clamp
module pidsci_out #(
  parameter int unsigned FracBits    = pidsci_pkg::FracBitsDefault,
  parameter int unsigned OutputFloor = pidsci_pkg::OutputFloorDefault
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [15:0]              output_max_i,
  input  pidsci_pkg::prod_stage_t  stage_i,
  output logic [15:0]              drive_o,
  output logic [16:0]              err_o,
  output logic                     used_o
);

  localparam logic [63:0] FloorWide = 64'(OutputFloor);

  logic [63:0] pi_q, pi_d;
  logic [50:0] d_q;
  logic [16:0] err_q;
  logic        used_q;

  logic [63:0] total;
  logic [63:0] shifted;
  logic [63:0] level;
  logic [15:0] drive_d;
  logic [15:0] drive_q;
  logic [16:0] err_out_q;
  logic        used_out_q;

  // proportional plus integral
  assign pi_d = pidsci_pkg::sat_add64({{14{stage_i.prod_p[49]}}, stage_i.prod_p},
                                      stage_i.prod_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pi_q   <= pi_d;
      d_q    <= stage_i.prod_d;
      err_q  <= stage_i.err;
      used_q <= stage_i.used;
    end
  end

  // add derivative, scale and clamp: floor first, then maximum
  assign total   = pidsci_pkg::sat_add64(pi_q, {{13{d_q[50]}}, d_q});
  assign shifted = total >> FracBits;
  always_comb begin
    if (total[63]) begin
      level = FloorWide;
    end else if (shifted <= FloorWide) begin
      level = FloorWide;
    end else begin
      level = shifted;
    end
    if (level >= {48'b0, output_max_i}) begin
      drive_d = output_max_i;
    end else begin
      drive_d = level[15:0];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drive_q    <= drive_d;
      err_out_q  <= err_q;
      used_out_q <= used_q;
    end
  end

  assign drive_o = drive_q;
  assign err_o   = err_out_q;
  assign used_o  = used_out_q;

endmodule

// ----- rtl/pid_step_conditional_integration.sv -----
// Positional PID step with integral separation and conditional integration.
// Input stream: one signed 16-bit measurement per request on s_axis_tdata.
// Output stream: m_axis_tdata carries the clamped drive and the error, and
// m_axis_tuser flags whether the integral term took part in this step.
// Configuration: one write channel, index 0..7 selects setpoint, gain_p, gain_i,
// gain_d, separation_limit, sum_upper, sum_lower, output_max; writes always
// complete in the cycle they are presented and are meant for idle periods.
// Throughput: one request per clock cycle unless the output stalls. The error,
// accumulator and error history update in the cycle a request is accepted, so
// the next sample sees them at once.
// Pipeline: the result passes the error stage, product stage, sum stage and
// result register in turn before it shows on the output.
// Stalls: while the receiver holds m_axis_tready low with a result waiting,
// the whole pipeline freezes and s_axis_tready drops; no result is lost.
// Reset: error sum and error history clear, registers take their defaults,
// the pipeline empties.
module pid_step_conditional_integration #(
  parameter int unsigned FracBits    = pidsci_pkg::FracBitsDefault,
  parameter int unsigned OutputFloor = pidsci_pkg::OutputFloorDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] measurement
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] drive, [32:16] error_value, zero pad
  output logic        m_axis_tuser,   // [0] integral_used
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [15:0] setpoint_q;
  logic [31:0] gain_p_q, gain_i_q, gain_d_q;
  logic [16:0] sep_limit_q;
  logic [31:0] sum_upper_q, sum_lower_q;
  logic [15:0] output_max_q;

  logic en;
  logic accept;
  logic v1_q, v2_q, v3_q, out_valid_q;

  pidsci_pkg::err_stage_t  err_stage;
  pidsci_pkg::prod_stage_t prod_stage;
  logic [15:0] drive;
  logic [16:0] err_value;
  logic        used;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= pidsci_pkg::SetpointRst;
      gain_p_q     <= pidsci_pkg::GainPRst;
      gain_i_q     <= pidsci_pkg::GainIRst;
      gain_d_q     <= pidsci_pkg::GainDRst;
      sep_limit_q  <= pidsci_pkg::SepLimitRst;
      sum_upper_q  <= pidsci_pkg::SumUpperRst;
      sum_lower_q  <= pidsci_pkg::SumLowerRst;
      output_max_q <= pidsci_pkg::OutMaxRst;
    end else if (cfg_valid_i) begin
      unique case (pidsci_pkg::cfg_reg_e'(cfg_index_i))
        pidsci_pkg::RegSetpoint:  setpoint_q   <= cfg_data_i[15:0];
        pidsci_pkg::RegGainP:     gain_p_q     <= cfg_data_i;
        pidsci_pkg::RegGainI:     gain_i_q     <= cfg_data_i;
        pidsci_pkg::RegGainD:     gain_d_q     <= cfg_data_i;
        pidsci_pkg::RegSepLimit:  sep_limit_q  <= cfg_data_i[16:0];
        pidsci_pkg::RegSumUpper:  sum_upper_q  <= cfg_data_i;
        pidsci_pkg::RegSumLower:  sum_lower_q  <= cfg_data_i;
        pidsci_pkg::RegOutputMax: output_max_q <= cfg_data_i[15:0];
      endcase
    end
  end

  // pipeline advances unless a finished result is held by the receiver
  assign en            = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid & en;

  // stage valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  pidsci_err u_err (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .accept_i    (accept),
    .meas_i      (s_axis_tdata),
    .setpoint_i  (setpoint_q),
    .sep_limit_i (sep_limit_q),
    .sum_upper_i (sum_upper_q),
    .sum_lower_i (sum_lower_q),
    .stage_o     (err_stage)
  );

  pidsci_mult u_mult (
    .clk_i    (clk_i),
    .en_i     (en),
    .gain_p_i (gain_p_q),
    .gain_i_i (gain_i_q),
    .gain_d_i (gain_d_q),
    .stage_i  (err_stage),
    .stage_o  (prod_stage)
  );

  pidsci_out #(
    .FracBits    (FracBits),
    .OutputFloor (OutputFloor)
  ) u_out (
    .clk_i        (clk_i),
    .en_i         (en),
    .output_max_i (output_max_q),
    .stage_i      (prod_stage),
    .drive_o      (drive),
    .err_o        (err_value),
    .used_o       (used)
  );

  // result stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, err_value, drive};
  assign m_axis_tuser  = used;

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench of the pid step block with integral separation
module tb_top;

  localparam int unsigned CycleLimit = 800000;
  localparam int unsigned IdlePct    = 21;
  localparam longint Int32Max = 64'sd2147483647;
  localparam longint Int32Min = -64'sd2147483648;
  localparam longint Int64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint Int64Min = 64'sh8000_0000_0000_0000;
  localparam longint DriveFloor = pidsci_pkg::OutputFloorDefault;

  // one expected result: drive, error and the integral flag
  typedef struct packed {
    logic [15:0] drive;
    logic [16:0] err;
    logic        used;
  } pid_result_t;

  // register image indexed by register index
  typedef logic [7:0][31:0] cfg_words_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] measurement
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [15:0] drive, [32:16] error_value, zero pad
  logic        m_axis_tuser;   // [0] integral_used
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  // predictor copy of the registers and the controller state
  logic [15:0] sp_q;
  logic [31:0] kp_q, ki_q, kd_q;
  logic [16:0] sep_q;
  logic [31:0] hi_q, lo_q;
  logic [15:0] omax_q;
  longint      sum_acc, err_last, err_prev;

  pid_result_t drive_expect_q[$];
  cfg_words_t  cfg_want;
  logic        steady;
  int unsigned err_count = 0;
  int unsigned cycle_cnt = 0;

  pid_step_conditional_integration dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // signed 64-bit add clipped to the 64-bit range
  function automatic longint sat_sum(input longint a, input longint b);
    if (b > 0 && a > Int64Max - b) return Int64Max;
    if (b < 0 && a < Int64Min - b) return Int64Min;
    return a + b;
  endfunction

  // one controller step: updates the state and returns the expected result
  function automatic pid_result_t pid_predict(input logic [15:0] meas);
    longint e, mag, hi, lo, lim, de, total, drv, omax;
    longint kp, ki, kd;
    logic used, add;
    pid_result_t r;
    e    = longint'($signed(sp_q)) - longint'($signed(meas));
    mag  = (e < 0) ? -e : e;
    hi   = longint'($signed(hi_q));
    lo   = longint'($signed(lo_q));
    lim  = sep_q;
    kp   = kp_q;
    ki   = ki_q;
    kd   = kd_q;
    omax = omax_q;
    used = (mag <= lim);
    // a zero history entry takes the current error
    if (err_last == 0) err_last = e;
    // conditional integration, upper level tested first
    if (sum_acc >= hi) add = used && (e < 0);
    else if (sum_acc <= lo) add = used && (e > 0);
    else add = used;
    if (add) begin
      sum_acc = sum_acc + e;
      if (sum_acc > Int32Max) sum_acc = Int32Max;
      if (sum_acc < Int32Min) sum_acc = Int32Min;
    end
    de       = err_last - err_prev;
    err_prev = err_last;
    err_last = e;
    total = kp * e;
    if (used) total = sat_sum(total, ki * sum_acc);
    total = sat_sum(total, kd * de);
    // floor first, then the configured maximum
    if (total < 0) begin
      drv = DriveFloor;
    end else begin
      drv = total >>> pidsci_pkg::FracBitsDefault;
      if (drv <= DriveFloor) drv = DriveFloor;
    end
    if (drv >= omax) drv = omax;
    r.drive = drv[15:0];
    r.err   = e[16:0];
    r.used  = used;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    err_count++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin : check_results
    pid_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_expect_q.size() == 0) begin
          report_mismatch("unexpected result, drive", -1, m_axis_tdata[15:0]);
        end else begin
          want = drive_expect_q.pop_front();
          if (m_axis_tdata[15:0] !== want.drive)
            report_mismatch("drive", want.drive, m_axis_tdata[15:0]);
          if (m_axis_tdata[32:16] !== want.err)
            report_mismatch("error_value", $signed(want.err), $signed(m_axis_tdata[32:16]));
          if (m_axis_tuser !== want.used)
            report_mismatch("integral_used", want.used, m_axis_tuser);
        end
      end
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // send one measurement request and record its expected result
  task automatic send_meas(input logic [15:0] meas);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= meas;
    do @(posedge clk_i); while (!s_axis_tready);
    drive_expect_q.push_back(pid_predict(meas));
  endtask

  // stop sending and let every result come out
  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // one register write; leaves the write valid high for back-to-back writes
  task automatic write_reg(input pidsci_pkg::cfg_reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pidsci_pkg::RegSetpoint:  sp_q   = data[15:0];
      pidsci_pkg::RegGainP:     kp_q   = data;
      pidsci_pkg::RegGainI:     ki_q   = data;
      pidsci_pkg::RegGainD:     kd_q   = data;
      pidsci_pkg::RegSepLimit:  sep_q  = data[16:0];
      pidsci_pkg::RegSumUpper:  hi_q   = data;
      pidsci_pkg::RegSumLower:  lo_q   = data;
      pidsci_pkg::RegOutputMax: omax_q = data[15:0];
      default: ;
    endcase
  endtask

  // write the whole register image once the block is idle
  task automatic program_regs(input cfg_words_t w);
    wait_drained();
    write_reg(pidsci_pkg::RegSetpoint,  w[pidsci_pkg::RegSetpoint]);
    write_reg(pidsci_pkg::RegGainP,     w[pidsci_pkg::RegGainP]);
    write_reg(pidsci_pkg::RegGainI,     w[pidsci_pkg::RegGainI]);
    write_reg(pidsci_pkg::RegGainD,     w[pidsci_pkg::RegGainD]);
    write_reg(pidsci_pkg::RegSepLimit,  w[pidsci_pkg::RegSepLimit]);
    write_reg(pidsci_pkg::RegSumUpper,  w[pidsci_pkg::RegSumUpper]);
    write_reg(pidsci_pkg::RegSumLower,  w[pidsci_pkg::RegSumLower]);
    write_reg(pidsci_pkg::RegOutputMax, w[pidsci_pkg::RegOutputMax]);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_gain(input int unsigned bits);
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      default: return $urandom() >> (32 - bits);
    endcase
  endfunction

  // random register image; narrow registers carry junk in unused bits
  function automatic cfg_words_t random_cfg();
    cfg_words_t w;
    int unsigned win;
    int i;
    for (i = 0; i < 8; i++) w[i] = $urandom();
    case ($urandom_range(0, 3))
      0: w[pidsci_pkg::RegSetpoint][15:0] = 16'h7FFF;
      1: w[pidsci_pkg::RegSetpoint][15:0] = 16'h8000;
      2: w[pidsci_pkg::RegSetpoint][15:0] = 16'h0000;
      default: ;
    endcase
    w[pidsci_pkg::RegGainP] = pick_gain(28);
    w[pidsci_pkg::RegGainI] = pick_gain(22);
    w[pidsci_pkg::RegGainD] = pick_gain(24);
    case ($urandom_range(0, 3))
      0: w[pidsci_pkg::RegSepLimit][16:0] = 17'h00000;
      1: w[pidsci_pkg::RegSepLimit][16:0] = 17'h1FFFF;
      2: w[pidsci_pkg::RegSepLimit][16:0] = 17'($urandom_range(0, 2000));
      default: ;
    endcase
    win = $urandom_range(0, 100000);
    case ($urandom_range(0, 3))
      0: begin
        w[pidsci_pkg::RegSumUpper] = 32'h7FFF_FFFF;
        w[pidsci_pkg::RegSumLower] = 32'h8000_0000;
      end
      1: begin
        w[pidsci_pkg::RegSumUpper] = win;
        w[pidsci_pkg::RegSumLower] = 32'(-int'(win));
      end
      2: begin
        // crossed levels
        w[pidsci_pkg::RegSumUpper] = 32'(-int'(win) - 1);
        w[pidsci_pkg::RegSumLower] = win;
      end
      default: ;
    endcase
    case ($urandom_range(0, 6))
      0: w[pidsci_pkg::RegOutputMax][15:0] = 16'd0;
      1: w[pidsci_pkg::RegOutputMax][15:0] = 16'd7999;
      2: w[pidsci_pkg::RegOutputMax][15:0] = 16'd8000;
      3: w[pidsci_pkg::RegOutputMax][15:0] = 16'd8001;
      4: w[pidsci_pkg::RegOutputMax][15:0] = 16'hFFFF;
      default: ;
    endcase
    return w;
  endfunction

  // measurement mostly near the setpoint, sometimes exact, sometimes anywhere
  function automatic logic [15:0] random_meas(input int unsigned span);
    int d;
    case ($urandom_range(0, 9))
      0:       return sp_q;
      1, 2:    return 16'($urandom());
      default: begin
        d = int'($urandom_range(0, 2 * span)) - int'(span);
        return 16'(int'($signed(sp_q)) - d);
      end
    endcase
  endfunction

  // out of reset: zero errors, full-scale errors of both signs, tiny errors
  task automatic test_reset_defaults;
    send_meas(16'h0000);
    send_meas(16'h0000);
    send_meas(16'h7FFF);
    send_meas(16'h8000);
    send_meas(16'h0001);
    send_meas(16'hFFFF);
  endtask

  // integral dropped just above the separation limit, kept at it
  task automatic test_integral_separation;
    cfg_want[pidsci_pkg::RegSetpoint] = 32'h0;
    cfg_want[pidsci_pkg::RegSepLimit] = 32'd100;
    program_regs(cfg_want);
    send_meas(16'(-100));
    send_meas(16'(-101));
    send_meas(16'(100));
    send_meas(16'(101));
    cfg_want[pidsci_pkg::RegSepLimit] = 32'd0;
    program_regs(cfg_want);
    send_meas(16'h0000);
    send_meas(16'hFFFF);
  endtask

  // accumulator at its levels only takes errors that pull it back
  task automatic test_conditional_integration;
    cfg_want[pidsci_pkg::RegSepLimit] = 32'h1FFFF;
    cfg_want[pidsci_pkg::RegSumUpper] = 32'd200;
    cfg_want[pidsci_pkg::RegSumLower] = 32'(-200);
    program_regs(cfg_want);
    send_meas(16'(-150));
    send_meas(16'(-150));
    send_meas(16'(-50));
    send_meas(16'(30));
    send_meas(16'(500));
    send_meas(16'(10));
    send_meas(16'(-40));
    // crossed levels: the upper test wins
    cfg_want[pidsci_pkg::RegSumUpper] = 32'(-5);
    cfg_want[pidsci_pkg::RegSumLower] = 32'd5;
    program_regs(cfg_want);
    send_meas(16'(3));
    send_meas(16'(-3));
  endtask

  // drive floor, maximum below the floor, zero maximum, negative total
  task automatic test_drive_clamp;
    cfg_want[pidsci_pkg::RegSumUpper]  = 32'h7FFF_FFFF;
    cfg_want[pidsci_pkg::RegSumLower]  = 32'h8000_0000;
    cfg_want[pidsci_pkg::RegGainP]     = 32'hFFFF_FFFF;
    cfg_want[pidsci_pkg::RegGainI]     = 32'h0;
    cfg_want[pidsci_pkg::RegGainD]     = 32'h0;
    cfg_want[pidsci_pkg::RegOutputMax] = 32'hFFFF;
    program_regs(cfg_want);
    send_meas(16'hFFFF);
    send_meas(16'(-2000));
    send_meas(16'h0001);
    cfg_want[pidsci_pkg::RegOutputMax] = 32'd7999;
    program_regs(cfg_want);
    send_meas(16'(-2000));
    send_meas(16'h0001);
    cfg_want[pidsci_pkg::RegOutputMax] = 32'd0;
    program_regs(cfg_want);
    send_meas(16'(-2000));
    cfg_want[pidsci_pkg::RegOutputMax] = 32'd8000;
    program_regs(cfg_want);
    send_meas(16'(-2000));
  endtask

  // full-scale errors of both signs back to back, no idling at all
  task automatic test_full_scale_burst;
    steady <= 1'b1;
    cfg_want[pidsci_pkg::RegSetpoint]  = 32'h7FFF;
    cfg_want[pidsci_pkg::RegGainP]     = pidsci_pkg::GainPRst;
    cfg_want[pidsci_pkg::RegGainI]     = 32'hFFFF_FFFF;
    cfg_want[pidsci_pkg::RegGainD]     = 32'hFFFF_FFFF;
    cfg_want[pidsci_pkg::RegSepLimit]  = 32'h1FFFF;
    cfg_want[pidsci_pkg::RegSumUpper]  = 32'h7FFF_FFFF;
    cfg_want[pidsci_pkg::RegSumLower]  = 32'h8000_0000;
    cfg_want[pidsci_pkg::RegOutputMax] = 32'hFFFF;
    program_regs(cfg_want);
    repeat (40) send_meas(16'h8000);
    cfg_want[pidsci_pkg::RegSetpoint] = 32'h8000;
    program_regs(cfg_want);
    repeat (40) send_meas(16'h7FFF);
    wait_drained();
    steady <= 1'b0;
  endtask

  // random settings per phase, random measurements with idling
  task automatic test_random_phases;
    int unsigned span;
    int unsigned n;
    repeat (10) begin
      cfg_want = random_cfg();
      program_regs(cfg_want);
      case ($urandom_range(0, 2))
        0:       span = $urandom_range(0, 50);
        1:       span = int'(sep_q) + 50;
        default: span = $urandom_range(0, 5000);
      endcase
      n = $urandom_range(80, 120);
      repeat (n) send_meas(random_meas(span));
    end
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= pidsci_pkg::RegSetpoint;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    steady        <= 1'b0;
    sp_q     = pidsci_pkg::SetpointRst;
    kp_q     = pidsci_pkg::GainPRst;
    ki_q     = pidsci_pkg::GainIRst;
    kd_q     = pidsci_pkg::GainDRst;
    sep_q    = pidsci_pkg::SepLimitRst;
    hi_q     = pidsci_pkg::SumUpperRst;
    lo_q     = pidsci_pkg::SumLowerRst;
    omax_q   = pidsci_pkg::OutMaxRst;
    sum_acc  = 0;
    err_last = 0;
    err_prev = 0;
    cfg_want[pidsci_pkg::RegSetpoint]  = {16'b0, pidsci_pkg::SetpointRst};
    cfg_want[pidsci_pkg::RegGainP]     = pidsci_pkg::GainPRst;
    cfg_want[pidsci_pkg::RegGainI]     = pidsci_pkg::GainIRst;
    cfg_want[pidsci_pkg::RegGainD]     = pidsci_pkg::GainDRst;
    cfg_want[pidsci_pkg::RegSepLimit]  = {15'b0, pidsci_pkg::SepLimitRst};
    cfg_want[pidsci_pkg::RegSumUpper]  = pidsci_pkg::SumUpperRst;
    cfg_want[pidsci_pkg::RegSumLower]  = pidsci_pkg::SumLowerRst;
    cfg_want[pidsci_pkg::RegOutputMax] = {16'b0, pidsci_pkg::OutMaxRst};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_integral_separation();
    test_conditional_integration();
    test_drive_clamp();
    test_full_scale_burst();
    test_random_phases();

    wait_drained();
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
